[hdl/hrsp_pkg.sv]
// Shared constants, payload type and the code threshold table for the
// tone map and sRGB encode pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hrsp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int INPUT_WIDTH = 25;
    localparam int MAG_W       = INPUT_WIDTH - 1;
    localparam int THR_W       = 32;
    localparam int PROD_W      = MAG_W + THR_W;
    localparam int CODE_W      = 8;
    localparam int NUM_CH      = 3;
    localparam int NUM_STEPS   = CODE_W;
    localparam int STEP_W      = 3;
    localparam int LINEAR_LAST = 10;

    typedef logic [255:0][THR_W-1:0] thr_tab_t;

    typedef struct packed {
        logic [NUM_CH-1:0][MAG_W-1:0]  mag;
        logic [NUM_CH-1:0][CODE_W-1:0] code;
    } hrsp_word_t;

    function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        return p[95:32];
    endfunction

    function automatic logic [63:0] fifth_q32(input logic [63:0] t);
        logic [63:0] sq;
        logic [63:0] quad;
        sq   = mul_q32(t, t);
        quad = mul_q32(sq, sq);
        return mul_q32(quad, t);
    endfunction

    // Linear value at which the encoded value reaches (k - 0.5) / 255.
    function automatic logic [63:0] code_threshold(input int k);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] root;
        logic [63:0] cand;
        logic [63:0] num;
        root = '0;
        if (k <= LINEAR_LAST) begin
            num = 64'(10 * k - 5) << 32;
            return num / 64'd32946;
        end
        num = 64'(200 * k + 2705) << 32;
        u   = num / 64'd53805;
        u2  = mul_q32(u, u);
        for (int b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (fifth_q32(cand) <= u2) begin
                root = cand;
            end
        end
        return mul_q32(u2, root);
    endfunction

    function automatic thr_tab_t build_thresholds();
        thr_tab_t tab;
        tab = '0;
        for (int k = 1; k < 256; k++) begin
            tab[k] = THR_W'(code_threshold(k));
        end
        return tab;
    endfunction

    localparam thr_tab_t THRESH = build_thresholds();

endpackage

`default_nettype wire

[hdl/hdr_reinhard_srgb_pixel_core.sv]
// Top level of the Reinhard tone map and sRGB byte encoder.
// Throughput: one pixel per cycle unless m_tready back-pressure stalls the
// pipeline; each of the eight code search bits has its own lookup, multiply
// and compare stages, so nothing is shared.
// Reset: synchronous, active low aresetn empties all pipeline stages.
// Uses hrsp_pkg and hrsp_search_step.
`timescale 1ns / 1ps
`default_nettype none

module hdr_reinhard_srgb_pixel_core
    import hrsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // red_linear [24:0], green_linear [49:25], blue_linear [74:50], zeros
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // red_code [7:0], green_code [15:8], blue_code [23:16]
    output logic [23:0]      m_tdata
);

    logic       in_valid_reg;
    hrsp_word_t in_word_reg, in_word_next;
    logic       in_ready;

    logic       [NUM_STEPS:0] st_valid;
    logic       [NUM_STEPS:0] st_ready;
    hrsp_word_t [NUM_STEPS:0] st_word;

    // A negative channel is treated as zero, which every threshold exceeds.
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            in_word_next.mag[c]  = s_tdata[c*INPUT_WIDTH + INPUT_WIDTH - 1] ? '0
                                 : s_tdata[c*INPUT_WIDTH +: MAG_W];
            in_word_next.code[c] = '0;
        end
    end

    assign in_ready = !in_valid_reg || st_ready[0];
    assign s_tready = in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            in_word_reg <= in_word_next;
        end
    end

    assign st_valid[0] = in_valid_reg;
    assign st_word[0]  = in_word_reg;

    for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
        hrsp_search_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (STEP_W'(i)),
            .in_valid  (st_valid[i]),
            .in_ready  (st_ready[i]),
            .in_word   (st_word[i]),
            .out_valid (st_valid[i+1]),
            .out_ready (st_ready[i+1]),
            .out_word  (st_word[i+1])
        );
    end

    assign st_ready[NUM_STEPS] = m_tready;
    assign m_tvalid = st_valid[NUM_STEPS];
    assign m_tdata  = {st_word[NUM_STEPS].code[2], st_word[NUM_STEPS].code[1],
                       st_word[NUM_STEPS].code[0]};

endmodule

`default_nettype wire

[hdl/hrsp_search_step.sv]
// One bit of the code search for all three channels, over two register
// stages: threshold lookup and multiply, then compare. Uses hrsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrsp_search_step
    import hrsp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [STEP_W-1:0] step,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire hrsp_word_t        in_word,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output hrsp_word_t             out_word
);

    logic                                a_valid_reg;
    hrsp_word_t                          a_word_reg;
    logic [NUM_CH-1:0][PROD_W-1:0]       a_lhs_reg, a_lhs_next;
    logic [NUM_CH-1:0][PROD_W-1:0]       a_rhs_reg, a_rhs_next;
    logic [NUM_CH-1:0][CODE_W-1:0]       a_cand_reg, a_cand_next;
    logic                                b_valid_reg;
    hrsp_word_t                          b_word_reg, b_word_next;
    logic                                a_ready;
    logic                                b_ready;
    logic [CODE_W-1:0]                   bit_mask;
    logic [THR_W-1:0]                    thr;

    assign bit_mask = CODE_W'(1) << (STEP_W'(CODE_W - 1) - step);

    // y >= L holds exactly when mag * (2^32 - L) >= L * 2^FRAC_BITS.
    always_comb begin
        thr = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            a_cand_next[c] = in_word.code[c] | bit_mask;
            thr            = THRESH[a_cand_next[c]];
            a_lhs_next[c]  = PROD_W'(in_word.mag[c]) * PROD_W'({1'b1, {THR_W{1'b0}}} - (THR_W+1)'(thr));
            a_rhs_next[c]  = PROD_W'(thr) << FRAC_BITS;
        end
    end

    always_comb begin
        b_word_next.mag = a_word_reg.mag;
        for (int c = 0; c < NUM_CH; c++) begin
            b_word_next.code[c] = (a_lhs_reg[c] >= a_rhs_reg[c]) ? a_cand_reg[c]
                                                                 : a_word_reg.code[c];
        end
    end

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_word_reg <= in_word;
            a_lhs_reg  <= a_lhs_next;
            a_rhs_reg  <= a_rhs_next;
            a_cand_reg <= a_cand_next;
        end
        if (b_ready) begin
            b_word_reg <= b_word_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_word  = b_word_reg;

endmodule

`default_nettype wire

[sim/hdr_reinhard_srgb_pixel_core_tb.sv]
// Self-checking testbench for the Reinhard tone map and sRGB byte encoder.
// Drives pixel words with random gaps and back-pressure and checks each result
// word against a fixed-point encoder model. Uses hrsp_pkg and the core RTL.
`timescale 1ns / 1ps

module hdr_reinhard_srgb_pixel_core_tb;
    import hrsp_pkg::*;

    localparam int LATENCY   = 17;
    localparam int N_RANDOM  = 430;
    localparam int WDOG_MAX  = 20000;

    typedef struct {
        logic [24:0] r;
        logic [24:0] g;
        logic [24:0] b;
        int          exp_code;   // -1 when the encoder model decides
    } pixel_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    logic [23:0] pending_codes[$];
    logic [31:0] level_tab[256];
    int          mismatches;
    int          words_in;
    int          words_out;
    int          idle_cycles;
    bit          hold_off;
    bit          no_idle;
    bit          stim_done;

    hdr_reinhard_srgb_pixel_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [63:0] q32_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        return p[95:32];
    endfunction

    // Linear level at which the encoded value crosses (k - 0.5) / 255.
    function automatic logic [31:0] srgb_level(input int k);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] root;
        logic [63:0] cand;
        logic [63:0] sq;
        logic [63:0] p5;
        root = '0;
        if (k <= 10)
            return 32'(((64'(10 * k - 5)) << 32) / 64'd32946);
        u  = ((64'(200 * k + 2705)) << 32) / 64'd53805;
        u2 = q32_product(u, u);
        for (int b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            sq   = q32_product(cand, cand);
            p5   = q32_product(q32_product(sq, sq), cand);
            if (p5 <= u2)
                root = cand;
        end
        return 32'(q32_product(u2, root));
    endfunction

    function automatic logic [7:0] encode_byte(input logic [24:0] x);
        logic [63:0] y;
        logic [7:0]  code;
        logic [7:0]  cand;
        code = '0;
        if (x[24] || x == '0)
            return 8'd0;
        y = ({39'd0, x} << 32) / ((64'd1 << FRAC_BITS) + 64'(x));
        for (int b = 7; b >= 0; b--) begin
            cand = code | (8'd1 << b);
            if (y >= 64'(level_tab[cand]))
                code = cand;
        end
        return code;
    endfunction

    function automatic logic [23:0] encode_pixel(input logic [24:0] r, input logic [24:0] g,
                                                 input logic [24:0] b);
        return {encode_byte(b), encode_byte(g), encode_byte(r)};
    endfunction

    // Biased channel: mostly around the useful range, some extremes and negatives.
    function automatic logic [24:0] random_channel();
        case ($urandom_range(0, 9))
            0: return 25'($urandom) | 25'h1000000;
            1: return 25'($urandom);
            2: return 25'($urandom_range(0, 64));
            3: return 25'($urandom_range(0, 2048));
            default: return 25'($urandom_range(0, 1 << 20));
        endcase
    endfunction

    // The word stays offered across calls; it is only withdrawn while idling or draining.
    task automatic send_pixel(input logic [24:0] r, input logic [24:0] g, input logic [24:0] b,
                              input int exp_code);
        logic [23:0] predicted;
        while (!no_idle && $urandom_range(0, 99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        predicted = encode_pixel(r, g, b);
        if (exp_code >= 0 && predicted != 24'(exp_code))
            $display("model disagrees with table row: %h vs %h", predicted, exp_code);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, b, g, r};
        pending_codes = {pending_codes, ((exp_code >= 0) ? 24'(exp_code) : predicted)};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_codes.size() != 0);
    endtask

    // Receiver: random stalls, plus a long forced hold-off on request.
    initial begin
        int stretch;
        m_tready <= 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                for (stretch = 0; stretch < 200; stretch++)
                    @(posedge aclk);
                hold_off = 1'b0;
            end
            m_tready <= no_idle || ($urandom_range(0, 99) >= 13);
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            words_out <= words_out + 1;
            if (pending_codes.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result word %h", m_tdata);
            end else begin
                logic [23:0] want;
                bit          bad;
                want = pending_codes.pop_front();
                bad  = 1'b0;
                for (int c = 0; c < 3; c++) begin
                    if (m_tdata[c*8 +: 8] != want[c*8 +: 8]) begin
                        if (mismatches < 10)
                            $display("channel %0d: expected %0d got %0d (word %0d)",
                                     c, want[c*8 +: 8], m_tdata[c*8 +: 8], words_out);
                        bad = 1'b1;
                    end
                end
                if (bad)
                    mismatches <= mismatches + 1;
            end
        end
        if (aresetn && s_tvalid && s_tready)
            words_in <= words_in + 1;
    end

    // Watchdog on cycles with no word moving in either direction.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        pixel_row_t rows[$];
        int         settle;
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        mismatches  = 0;
        words_in    = 0;
        words_out   = 0;
        idle_cycles = 0;
        hold_off    = 1'b0;
        no_idle     = 1'b0;
        stim_done   = 1'b0;
        for (int k = 0; k < 256; k++)
            level_tab[k] = (k == 0) ? 32'd0 : srgb_level(k);

        // Zero, negatives and the largest input have obvious codes.
        rows = {rows, pixel_row_t'{25'd0, 25'd0, 25'd0, 0}};
        rows = {rows, pixel_row_t'{25'h1000000, 25'h1FFFFFF, 25'h1800000, 0}};
        rows = {rows, pixel_row_t'{25'hFFFFFF, 25'hFFFFFF, 25'hFFFFFF, 24'hFFFFFF}};
        rows = {rows, pixel_row_t'{25'hFFFFFF, 25'd0, 25'h1FFFFFF, 24'h0000FF}};
        rows = {rows, pixel_row_t'{25'd1, 25'd2, 25'd3, -1}};
        rows = {rows, pixel_row_t'{25'd10, 25'd13, 25'd14, -1}};
        rows = {rows, pixel_row_t'{25'h10000, 25'h8000, 25'h20000, -1}};
        rows = {rows, pixel_row_t'{25'd200, 25'd220, 25'd240, -1}};
        rows = {rows, pixel_row_t'{25'h155555, 25'h0AAAAA, 25'h1FFFF, -1}};
        rows = {rows, pixel_row_t'{25'h800000, 25'h400000, 25'h1, -1}};
        // Inputs that land on or just beside a threshold edge, computed from level_tab.
        for (int k = 1; k < 256; k += 50) begin
            logic [24:0] x;
            x = 25'((64'(level_tab[k]) << FRAC_BITS) / ((64'd1 << 32) - 64'(level_tab[k])));
            rows = {rows, pixel_row_t'{x, x + 25'd1, (x == 0) ? x : x - 25'd1, -1}};
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i])
            send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].exp_code);

        // Sender pauses until the pipeline has emptied.
        drain_results();

        // Receiver holds off for a long stretch while words keep coming.
        hold_off = 1'b1;
        for (int i = 0; i < 60; i++)
            send_pixel(random_channel(), random_channel(), random_channel(), -1);

        for (int i = 0; i < N_RANDOM; i++) begin
            no_idle = (i >= 200 && i < 300);
            send_pixel(random_channel(), random_channel(), random_channel(), -1);
        end
        no_idle   = 1'b0;
        stim_done = 1'b1;

        drain_results();
        for (settle = 0; settle < 4 * LATENCY; settle++)
            @(posedge aclk);

        $display("Sent %0d pixel words (zero, negative, full scale, threshold edges, random)",
                 words_in);
        $display("with random gaps, long back-pressure and a drained pause; %0d results checked",
                 words_out);
        if (mismatches == 0 && pending_codes.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
